@@ design/slc_pkg.sv @@
package slc_pkg;

    localparam int SETS       = 256;
    localparam int WAYS       = 8;
    localparam int ROWS       = 2 * SETS;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int SET_W      = $clog2(SETS);
    localparam int WAY_W      = $clog2(WAYS);
    localparam int TAG_W      = 30;
    localparam int AGE_W      = 3;
    localparam int CNT_W      = 12;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    localparam logic [2:0] REG_SPLIT   = 3'd0;
    localparam logic [2:0] REG_OFFSET  = 3'd1;
    localparam logic [2:0] REG_USETS   = 3'd2;
    localparam logic [2:0] REG_ISETS   = 3'd3;
    localparam logic [2:0] REG_DSETS   = 3'd4;
    localparam logic [2:0] REG_WAYS    = 3'd5;
    localparam logic [2:0] REG_WBACK   = 3'd6;
    localparam logic [2:0] REG_WALLOC  = 3'd7;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic        replaced;
        logic        is_instruction;
        logic [6:0]  fetch_words;
        logic [17:0] copy_back_words;
    } rsp_t;

    typedef struct packed {
        logic       split_mode;
        logic [3:0] offset_bits;
        logic [3:0] unified_set_bits;
        logic [3:0] instr_set_bits;
        logic [3:0] data_set_bits;
        logic [3:0] ways_in_use;
        logic       write_back;
        logic       write_allocate;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [ROW_W-1:0] row;
        logic [TAG_W-1:0] tag;
        logic [SET_W-1:0] last;
    } job_t;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic clear_done;
    } back_stat_t;

    function automatic logic [3:0] eff_off(input logic [3:0] b);
        logic [3:0] r;
        r = b;
        if (b < 4'd2) r = 4'd2;
        if (b > 4'd8) r = 4'd8;
        return r;
    endfunction

    function automatic logic [3:0] eff_sb(input logic [3:0] b);
        return (b > 4'd8) ? 4'd8 : b;
    endfunction

    function automatic logic [3:0] eff_ways(input logic [3:0] w);
        logic [3:0] r;
        r = w;
        if (w < 4'd1) r = 4'd1;
        if (w > 4'(WAYS)) r = 4'(WAYS);
        return r;
    endfunction

endpackage

@@ design/slc_front.sv @@
module slc_front
    import slc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [3:0] cfg_data,
    input  back_stat_t stat,
    input  logic       q_full,
    output logic       push,
    output job_t       job,
    output cfg_t       cfg
);

    cfg_t       cfg_reg;
    logic [3:0] off;
    logic [3:0] sb;
    logic [3:0] fb;
    logic [4:0] tag_sh;
    logic [31:0] set_full;
    logic [31:0] tag_full;
    logic [8:0] set_mask;
    logic [8:0] flush_mask;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{split_mode: 1'b0, offset_bits: 4'd5, unified_set_bits: 4'd6,
                         instr_set_bits: 4'd6, data_set_bits: 4'd6, ways_in_use: 4'd1,
                         write_back: 1'b1, write_allocate: 1'b1};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SPLIT:  cfg_reg.split_mode       <= cfg_data[0];
                REG_OFFSET: cfg_reg.offset_bits      <= cfg_data;
                REG_USETS:  cfg_reg.unified_set_bits <= cfg_data;
                REG_ISETS:  cfg_reg.instr_set_bits   <= cfg_data;
                REG_DSETS:  cfg_reg.data_set_bits    <= cfg_data;
                REG_WAYS:   cfg_reg.ways_in_use      <= cfg_data;
                REG_WBACK:  cfg_reg.write_back       <= cfg_data[0];
                REG_WALLOC: cfg_reg.write_allocate   <= cfg_data[0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // classify: pick the cache half, split the address into set and tag
    always_comb
    begin
        off = eff_off(cfg_reg.offset_bits);
        if (!cfg_reg.split_mode)
            sb = eff_sb(cfg_reg.unified_set_bits);
        else if (req.command == CMD_FETCH)
            sb = eff_sb(cfg_reg.instr_set_bits);
        else
            sb = eff_sb(cfg_reg.data_set_bits);
        fb = eff_sb(cfg_reg.split_mode ? cfg_reg.data_set_bits : cfg_reg.unified_set_bits);
        tag_sh     = {1'b0, off} + {1'b0, sb};
        set_full   = req.address >> off;
        tag_full   = req.address >> tag_sh;
        set_mask   = (9'd1 << sb) - 9'd1;
        flush_mask = (9'd1 << fb) - 9'd1;
        job.cmd = req.command;
        job.tag = tag_full[TAG_W-1:0];
        if (req.command == CMD_FLUSH)
        begin
            job.row  = {cfg_reg.split_mode, {SET_W{1'b0}}};
            job.last = flush_mask[SET_W-1:0];
        end
        else
        begin
            job.row  = {cfg_reg.split_mode && (req.command != CMD_FETCH),
                        set_full[SET_W-1:0] & set_mask[SET_W-1:0]};
            job.last = '0;
        end
    end

    assign req_ready = !q_full && stat.clear_done;
    assign push      = req_valid && req_ready;

endmodule

@@ design/slc_queue.sv @@
module slc_queue
    import slc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t din,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output job_t dout
);

    job_t       ent_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign dout    = ent_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ design/slc_back.sv @@
module slc_back
    import slc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       pop,
    output back_stat_t stat,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp
);

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_FREAD, ST_FACC, ST_FDONE} state_t;

    state_t           state_reg;
    logic [ROW_W-1:0] clr_reg;
    job_t             job_reg;
    logic [SET_W-1:0] fcnt_reg;
    logic [CNT_W-1:0] dirty_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    row_t             mem [ROWS];
    row_t             rd_reg;
    logic [ROW_W-1:0] raddr;
    logic [ROW_W-1:0] waddr;
    row_t             wdata;
    logic             we;

    logic             slot_ok;
    logic             rsp_load;
    logic [3:0]       off;
    logic [3:0]       nways;
    logic [6:0]       words;
    logic [WAY_W-1:0] found;
    logic             found_any;
    logic [WAY_W-1:0] victim;
    logic [WAY_W-1:0] tgt;
    logic             is_store;
    logic             alloc;
    logic             touch_en;
    logic [AGE_W-1:0] old_age;
    row_t             new_row;
    rsp_t             acc_rsp;
    logic [3:0]       row_dirty;
    logic [17:0]      flush_copy;

    assign slot_ok    = !rsp_valid_reg || rsp_ready;
    assign rsp_load   = slot_ok && ((state_reg == ST_EXEC) || (state_reg == ST_FDONE));
    assign stat.clear_done = (state_reg != ST_CLEAR);
    assign pop        = (state_reg == ST_IDLE) && q_valid;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign off        = eff_off(cfg.offset_bits);
    assign nways      = eff_ways(cfg.ways_in_use);
    assign words      = 7'd1 << (off - 4'd2);
    assign flush_copy = 18'(dirty_reg) << (off - 4'd2);
    assign is_store   = (job_reg.cmd == CMD_STORE);

    // keep the set row of a stalled access in the read register
    always_comb
    begin
        if (state_reg == ST_IDLE)
            raddr = q_job.row;
        else if (state_reg == ST_EXEC)
            raddr = job_reg.row;
        else
            raddr = {job_reg.row[ROW_W-1], fcnt_reg};
    end

    // lookup, victim choice and LRU update on the row just read
    always_comb
    begin
        found     = '0;
        found_any = 1'b0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if ((4'(i) < nways) && rd_reg[i].valid && (rd_reg[i].tag == job_reg.tag))
            begin
                found     = WAY_W'(i);
                found_any = 1'b1;
            end
        end
        victim = '0;
        for (int i = 1; i < WAYS; i++)
        begin
            if ((4'(i) < nways) && (rd_reg[i].age > rd_reg[victim].age))
                victim = WAY_W'(i);
        end
        tgt      = found_any ? found : victim;
        alloc    = !found_any && !(is_store && !cfg.write_allocate);
        touch_en = found_any || alloc;
        old_age  = rd_reg[tgt].age;
        new_row  = rd_reg;
        acc_rsp  = '0;
        acc_rsp.is_instruction = (job_reg.cmd == CMD_FETCH);
        if (found_any)
        begin
            acc_rsp.hit = 1'b1;
            if (is_store)
            begin
                new_row[tgt].dirty = cfg.write_back;
                acc_rsp.copy_back_words = 18'(!cfg.write_back);
            end
        end
        else if (!alloc)
        begin
            acc_rsp.copy_back_words = 18'd1;
        end
        else
        begin
            if (rd_reg[tgt].valid)
            begin
                acc_rsp.replaced = 1'b1;
                if (rd_reg[tgt].dirty && (!is_store || cfg.write_back))
                    acc_rsp.copy_back_words = 18'(words);
            end
            acc_rsp.fetch_words = words;
            new_row[tgt].valid  = 1'b1;
            new_row[tgt].tag    = job_reg.tag;
            new_row[tgt].dirty  = is_store && cfg.write_back;
            if (is_store && !cfg.write_back)
                acc_rsp.copy_back_words = acc_rsp.copy_back_words + 18'd1;
        end
        if (touch_en)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                if ((4'(i) < nways) && (WAY_W'(i) != tgt) && (rd_reg[i].age < old_age)
                    && (rd_reg[i].age < AGE_W'(WAYS - 1)))
                    new_row[i].age = rd_reg[i].age + AGE_W'(1);
            end
            new_row[tgt].age = '0;
        end
        row_dirty = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if ((4'(i) < nways) && rd_reg[i].valid && rd_reg[i].dirty)
                row_dirty = row_dirty + 4'd1;
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = job_reg.row;
        wdata = new_row;
        if (state_reg == ST_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            for (int i = 0; i < WAYS; i++)
                wdata[i] = '{valid: 1'b0, dirty: 1'b0, age: AGE_W'(i), tag: '0};
        end
        else if ((state_reg == ST_EXEC) && slot_ok)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            fcnt_reg      <= '0;
            dirty_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && !rsp_load)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + ROW_W'(1);
                    if (clr_reg == ROW_W'(ROWS - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        fcnt_reg  <= '0;
                        dirty_reg <= '0;
                        state_reg <= (q_job.cmd == CMD_FLUSH) ? ST_FREAD : ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (slot_ok)
                    begin
                        rsp_reg       <= acc_rsp;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_FREAD:
                begin
                    state_reg <= ST_FACC;
                end
                ST_FACC:
                begin
                    dirty_reg <= dirty_reg + CNT_W'(row_dirty);
                    if (fcnt_reg == job_reg.last)
                        state_reg <= ST_FDONE;
                    else
                    begin
                        fcnt_reg  <= fcnt_reg + SET_W'(1);
                        state_reg <= ST_FREAD;
                    end
                end
                ST_FDONE:
                begin
                    if (slot_ok)
                    begin
                        rsp_reg       <= '{hit: 1'b0, replaced: 1'b0, is_instruction: 1'b0,
                                           fetch_words: 7'd0, copy_back_words: flush_copy};
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/set_assoc_lru_cache_model.sv @@
// Flow: a load, store or fetch request waits in the queue, then one line-store read and
// one read-modify-write of the set row produce its result in the output register.
// Flush: every set row of the flushed half is read and its dirty lines are counted.
// Accesses run one at a time; a 2-entry queue decouples intake from execution.
// Reset: asynchronous, active low; configuration returns to its defaults, then a clearing
// pass rewrites every set row while no request is taken.
module set_assoc_lru_cache_model
    import slc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [3:0] cfg_data
);

    // front side: configuration registers and request classification
    back_stat_t stat;
    cfg_t       cfg;
    job_t       push_job;
    job_t       q_job;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_valid;

    slc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job),
        .cfg       (cfg)
    );

    // hold classified requests until the back end is free
    slc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .din     (push_job),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .dout    (q_job)
    );

    // back end: line store, LRU update, flush walk and the output register
    slc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    import slc_pkg::*;

    // Line store of the cache under test: lower half unified or instruction
    // side, upper half data side, eight ways per set row.
    localparam int HALF  = 256 * 8;
    localparam int LINES = 2 * HALF;
    localparam int WATCHDOG_LIMIT = 6000;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [3:0] cfg_data;

    set_assoc_lru_cache_model dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the line store and of the configuration
    logic        shadow_valid [LINES];
    logic [31:0] shadow_tag   [LINES];
    logic        shadow_dirty [LINES];
    logic [2:0]  shadow_age   [LINES];
    cfg_t        shadow_cfg;

    rsp_t pending_rsp[$];
    int   mismatches;
    int   requests_sent;
    int   responses_seen;
    int   flushes_sent;
    int   hits_seen;
    int   phases_run;
    int   quiet_cycles;
    bit   idle_on;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int clamp_offset(input logic [3:0] b);
        if (b < 2) return 2;
        if (b > 8) return 8;
        return b;
    endfunction

    function automatic int clamp_sets(input logic [3:0] b);
        return (b > 8) ? 8 : b;
    endfunction

    function automatic int clamp_ways(input logic [3:0] w);
        if (w < 1) return 1;
        if (w > 8) return 8;
        return w;
    endfunction

    // Mark a way most recent; age the younger ones, saturating at 7
    function automatic void promote_way(input int base, input int nways, input int way);
        logic [2:0] old;
        old = shadow_age[base + way];
        for (int w = 0; w < nways; w++)
        begin
            if (w != way && shadow_age[base + w] < old && shadow_age[base + w] < 3'd7)
                shadow_age[base + w] = shadow_age[base + w] + 3'd1;
        end
        shadow_age[base + way] = 3'd0;
    endfunction

    // Work out the cache's answer to one request and advance the shadow state
    function automatic rsp_t cache_outcome(input req_t r);
        rsp_t  o;
        int    nways;
        int    off;
        int    sb;
        int    words;
        int    base;
        int    found;
        int    victim;
        int    dirty;
        int    k;
        logic [31:0] set_idx;
        logic [31:0] tag;
        bit    data_side;
        o = '0;
        nways = clamp_ways(shadow_cfg.ways_in_use);
        off = clamp_offset(shadow_cfg.offset_bits);
        words = (1 << off) / 4;
        o.is_instruction = (r.command == CMD_FETCH);
        if (r.command == CMD_FLUSH)
        begin
            // Count dirty lines of the flushed half; lines stay dirty
            sb = clamp_sets(shadow_cfg.split_mode ? shadow_cfg.data_set_bits
                                                  : shadow_cfg.unified_set_bits);
            base = shadow_cfg.split_mode ? HALF : 0;
            dirty = 0;
            for (int s = 0; s < (1 << sb); s++)
                for (int w = 0; w < nways; w++)
                    if (shadow_valid[base + s * 8 + w] && shadow_dirty[base + s * 8 + w])
                        dirty++;
            o.copy_back_words = (dirty * words > 262143) ? 18'h3FFFF : 18'(dirty * words);
            return o;
        end
        data_side = shadow_cfg.split_mode && r.command != CMD_FETCH;
        if (!shadow_cfg.split_mode)
            sb = clamp_sets(shadow_cfg.unified_set_bits);
        else if (r.command == CMD_FETCH)
            sb = clamp_sets(shadow_cfg.instr_set_bits);
        else
            sb = clamp_sets(shadow_cfg.data_set_bits);
        set_idx = (r.address >> off) & ((32'd1 << sb) - 32'd1);
        tag = r.address >> (off + sb);
        base = (data_side ? HALF : 0) + int'(set_idx) * 8;
        found = nways;
        victim = 0;
        for (int w = 0; w < nways; w++)
        begin
            if (found == nways && shadow_valid[base + w] && shadow_tag[base + w] == tag)
                found = w;
        end
        for (int w = 1; w < nways; w++)
        begin
            if (shadow_age[base + w] > shadow_age[base + victim])
                victim = w;
        end
        if (found < nways)
        begin
            o.hit = 1'b1;
            if (r.command == CMD_STORE)
            begin
                if (shadow_cfg.write_back)
                    shadow_dirty[base + found] = 1'b1;
                else
                begin
                    shadow_dirty[base + found] = 1'b0;
                    o.copy_back_words = 18'd1;
                end
            end
            promote_way(base, nways, found);
        end
        else if (r.command == CMD_STORE && !shadow_cfg.write_allocate)
        begin
            // Store miss without allocation: write the word through only
            o.copy_back_words = 18'd1;
        end
        else
        begin
            k = base + victim;
            if (shadow_valid[k])
            begin
                o.replaced = 1'b1;
                if (shadow_dirty[k] && (r.command != CMD_STORE || shadow_cfg.write_back))
                    o.copy_back_words = 18'(words);
            end
            o.fetch_words = 7'(words);
            shadow_valid[k] = 1'b1;
            shadow_tag[k] = tag;
            shadow_dirty[k] = 1'b0;
            if (r.command == CMD_STORE)
            begin
                if (shadow_cfg.write_back)
                    shadow_dirty[k] = 1'b1;
                else
                    o.copy_back_words = o.copy_back_words + 18'd1;
            end
            promote_way(base, nways, victim);
        end
        return o;
    endfunction

    // Present one request, wait for acceptance, queue its expected answer.
    // The caller lowers req_valid in the acceptance step once the batch ends.
    task automatic issue_request(input logic [1:0] cmd, input logic [31:0] addr,
                                 input bit typed, input rsp_t typed_rsp);
        req_t r;
        rsp_t predicted;
        r.command = cmd;
        r.address = addr;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        predicted = cache_outcome(r);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        requests_sent++;
        if (cmd == CMD_FLUSH)
            flushes_sent++;
    endtask

    task automatic drain_responses();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all eight registers back to back; only called with the block idle
    task automatic load_config(input cfg_t c);
        logic [3:0] values [8];
        logic [2:0] order [8];
        values[0] = {3'd0, c.split_mode};
        values[1] = c.offset_bits;
        values[2] = c.unified_set_bits;
        values[3] = c.instr_set_bits;
        values[4] = c.data_set_bits;
        values[5] = c.ways_in_use;
        values[6] = {3'd0, c.write_back};
        values[7] = {3'd0, c.write_allocate};
        order = '{REG_SPLIT, REG_OFFSET, REG_USETS, REG_ISETS,
                  REG_DSETS, REG_WAYS, REG_WBACK, REG_WALLOC};
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data <= values[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        shadow_cfg = c;
        phases_run++;
    endtask

    // Response side: hold off ready in random bursts while idling is on
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && rsp_ready && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    // Compare each response with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            responses_seen++;
            if (pending_rsp.size() == 0)
            begin
                $error("response with nothing outstanding: %h", rsp);
                mismatches++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.hit) hits_seen++;
                if (rsp.hit !== want.hit)
                begin
                    $error("hit: expected %0d actual %0d", want.hit, rsp.hit);
                    mismatches++;
                end
                if (rsp.replaced !== want.replaced)
                begin
                    $error("replaced: expected %0d actual %0d", want.replaced, rsp.replaced);
                    mismatches++;
                end
                if (rsp.is_instruction !== want.is_instruction)
                begin
                    $error("is_instruction: expected %0d actual %0d",
                           want.is_instruction, rsp.is_instruction);
                    mismatches++;
                end
                if (rsp.fetch_words !== want.fetch_words)
                begin
                    $error("fetch_words: expected %0d actual %0d",
                           want.fetch_words, rsp.fetch_words);
                    mismatches++;
                end
                if (rsp.copy_back_words !== want.copy_back_words)
                begin
                    $error("copy_back_words: expected %0d actual %0d",
                           want.copy_back_words, rsp.copy_back_words);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: stop if no handshake completes for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d responses outstanding", pending_rsp.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] addr;
        bit          typed;
        rsp_t        typed_rsp;
    } step_t;

    step_t       directed [];
    logic [31:0] hot_addr [16];
    cfg_t        c;

    initial
    begin
        int   draw;
        logic [1:0]  cmd;
        logic [31:0] addr;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SPLIT;
        cfg_data = '0;
        mismatches = 0;
        requests_sent = 0;
        responses_seen = 0;
        flushes_sent = 0;
        hits_seen = 0;
        phases_run = 0;
        quiet_cycles = 0;
        idle_on = 1'b1;
        for (int i = 0; i < LINES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_tag[i] = '0;
            shadow_dirty[i] = 1'b0;
            shadow_age[i] = 3'(i % 8);
        end
        shadow_cfg = '{split_mode: 1'b0, offset_bits: 4'd5, unified_set_bits: 4'd6,
                       instr_set_bits: 4'd6, data_set_bits: 4'd6, ways_in_use: 4'd1,
                       write_back: 1'b1, write_allocate: 1'b1};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset configuration: unified, 32-byte
        // blocks, 64 sets, direct mapped, write-back with allocation.
        // Typed answers: (hit, replaced, is_instruction, fetch, copy-back).
        directed = new[12];
        directed[0]  = '{CMD_FLUSH, 32'h0000_0000, 1, '{0, 0, 0, 7'd0, 18'd0}};
        directed[1]  = '{CMD_LOAD,  32'h0000_0000, 1, '{0, 0, 0, 7'd8, 18'd0}};
        directed[2]  = '{CMD_LOAD,  32'h0000_001C, 1, '{1, 0, 0, 7'd0, 18'd0}};
        directed[3]  = '{CMD_FETCH, 32'h0000_0004, 1, '{1, 0, 1, 7'd0, 18'd0}};
        directed[4]  = '{CMD_STORE, 32'h0000_0008, 1, '{1, 0, 0, 7'd0, 18'd0}};
        directed[5]  = '{CMD_FLUSH, 32'hFFFF_FFFF, 1, '{0, 0, 0, 7'd0, 18'd8}};
        directed[6]  = '{CMD_LOAD,  32'h0000_0800, 1, '{0, 1, 0, 7'd8, 18'd8}};
        directed[7]  = '{CMD_LOAD,  32'hFFFF_FFFF, 0, '0};
        directed[8]  = '{CMD_STORE, 32'hFFFF_FFFF, 0, '0};
        directed[9]  = '{CMD_FETCH, 32'h8000_0000, 0, '0};
        directed[10] = '{CMD_STORE, 32'h1234_5678, 0, '0};
        directed[11] = '{CMD_FLUSH, 32'h0000_0000, 0, '0};
        @(posedge clk);
        foreach (directed[i])
            issue_request(directed[i].cmd, directed[i].addr,
                          directed[i].typed, directed[i].typed_rsp);
        req_valid <= 1'b0;
        drain_responses();

        // Phases of random requests; the first ones pin the register extremes,
        // including out-of-range values that must saturate.
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0: c = '{1'b1, 4'd0,  4'd15, 4'd0, 4'd8, 4'd0,  1'b0, 1'b0};
                1: c = '{1'b0, 4'd15, 4'd0,  4'd8, 4'd0, 4'd15, 1'b1, 1'b0};
                2: c = '{1'b1, 4'd8,  4'd8,  4'd15, 4'd15, 4'd8, 1'b0, 1'b1};
                3: c = '{1'b0, 4'd2,  4'd8,  4'd1, 4'd1, 4'd8,  1'b1, 1'b1};
                4: c = '{1'b1, 4'd2,  4'd1,  4'd2, 4'd2, 4'd4,  1'b1, 1'b1};
                default:
                begin
                    c.split_mode = 1'($urandom_range(0, 1));
                    c.offset_bits = 4'($urandom_range(0, 15));
                    c.unified_set_bits = 4'($urandom_range(0, 15));
                    c.instr_set_bits = 4'($urandom_range(0, 15));
                    c.data_set_bits = 4'($urandom_range(0, 15));
                    c.ways_in_use = 4'($urandom_range(0, 15));
                    c.write_back = 1'($urandom_range(0, 1));
                    c.write_allocate = 1'($urandom_range(0, 1));
                end
            endcase
            load_config(c);
            // A small pool of addresses forces reuse, conflicts and evictions
            foreach (hot_addr[i])
                hot_addr[i] = $urandom();
            // Drop idling for the final stretch of the run
            if (phase >= 10)
                idle_on = 1'b0;
            for (int n = 0; n < 90; n++)
            begin
                draw = $urandom_range(0, 99);
                cmd = (draw < 4) ? CMD_FLUSH : 2'($urandom_range(0, 2));
                if ($urandom_range(0, 9) == 0)
                    addr = $urandom();
                else
                    addr = hot_addr[$urandom_range(0, 15)] ^ 32'($urandom_range(0, 255));
                issue_request(cmd, addr, 0, '0);
            end
            req_valid <= 1'b0;
            // Hold the sender until every outstanding response is back
            drain_responses();
        end

        repeat (20) @(posedge clk);
        $display("ran %0d requests (%0d flushes) over %0d register settings",
                 requests_sent, flushes_sent, phases_run);
        $display("%0d responses checked, %0d of them hits", responses_seen, hits_seen);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
design/slc_pkg.sv
design/slc_front.sv
design/slc_queue.sv
design/slc_back.sv
design/set_assoc_lru_cache_model.sv
verif/tb_top.sv
